FILE: rtl/core/rrs_pkg.sv
// Shared types and codes for the round-robin process scheduler.
// Request, result and table-entry layouts plus command and slot-status codes.
// No dependencies.
package rrs_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	// Command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WAIT  = 2'd1;
	localparam logic [1:0] CMD_KILL  = 2'd2;
	localparam logic [1:0] CMD_SPAWN = 2'd3;

	// Slot status codes
	localparam logic [1:0] ST_DEAD    = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_WAITING = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] target_slot;
	} req_t;

	typedef struct packed {
		logic [3:0] running_slot;
		logic [3:0] spawned_slot;
	} res_t;

	// One slot of the task table
	typedef struct packed {
		logic [3:0] wait_on;
		logic [1:0] status;
	} entry_t;

endpackage

FILE: rtl/core/rrs_mem.sv
// Task table memory: one write port, one registered read port, write-to-read forwarding.
// Per-entry valid bits make unwritten slots read as dead. Depends on rrs_pkg.
module rrs_mem import rrs_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
	output entry_t                        rd_entry,
	input  logic                          wr_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
	input  entry_t                        wr_entry
);

	entry_t                  mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   vld_q;
	entry_t                  rd_data_q;
	logic                    rd_vld_q;
	logic                    hit;

	assign hit = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= hit ? wr_entry : mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= hit || vld_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/core/rrs_seq.sv
// Command sequencer: read-modify-write over the task table, round-robin scan.
// Holds the running slot and the spawn flag. Depends on rrs_pkg.
module rrs_seq import rrs_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  req_t                          req,
	output logic                          idle,
	output logic                          done,
	output res_t                          res,
	input  logic                          out_free,
	output logic                          rd_en,
	output logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
	input  entry_t                        rd_entry,
	output logic                          wr_en,
	output logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
	output entry_t                        wr_entry
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DEMOTE    = 3'd1;
	localparam logic [2:0] S_SCAN_ADDR = 3'd2;
	localparam logic [2:0] S_SCAN_CHK  = 3'd3;
	localparam logic [2:0] S_TGT_CHK   = 3'd4;
	localparam logic [2:0] S_SPAWN_CHK = 3'd5;
	localparam logic [2:0] S_DONE      = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [IDX_W-1:0] spawned_q, spawned_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic             looped_q, looped_d;
	logic             any_q, any_d;
	logic [CNT_W-1:0] next_cnt;
	logic [IDX_W-1:0] scan_idx;
	logic             next_in;

	assign next_cnt = scan_q + CNT_W'(1);
	assign next_in  = 32'(next_cnt) < SLOT_COUNT;
	assign scan_idx = scan_q[IDX_W-1:0];

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		spawned_d = spawned_q;
		scan_d    = scan_q;
		looped_d  = looped_q;
		any_d     = any_q;
		rd_en     = 1'b0;
		rd_addr   = scan_idx;
		wr_en     = 1'b0;
		wr_addr   = scan_idx;
		wr_entry  = '0;
		unique case (state_q) inside
			S_IDLE: begin
				if (start) begin
					spawned_d = '0;
					unique case (req.command)
						CMD_TICK: begin
							if (any_q) begin
								rd_en   = 1'b1;
								rd_addr = cur_q;
								state_d = S_DEMOTE;
							end else begin
								state_d = S_DONE;
							end
						end
						CMD_WAIT: begin
							wr_en            = 1'b1;
							wr_addr          = cur_q;
							wr_entry.wait_on = req.target_slot;
							wr_entry.status  = ST_WAITING;
							if (any_q) begin
								scan_d   = CNT_W'(cur_q) + CNT_W'(1);
								looped_d = 1'b0;
								state_d  = S_SCAN_ADDR;
							end else begin
								state_d = S_DONE;
							end
						end
						CMD_KILL: begin
							if (32'(req.target_slot) < SLOT_COUNT) begin
								wr_en           = 1'b1;
								wr_addr         = IDX_W'(req.target_slot);
								wr_entry.status = ST_DEAD;
							end
							state_d = S_DONE;
						end
						CMD_SPAWN: begin
							rd_en   = 1'b1;
							rd_addr = IDX_W'(1);
							scan_d  = CNT_W'(1);
							state_d = S_SPAWN_CHK;
						end
					endcase
				end
			end
			S_DEMOTE: begin
				// demote the running slot before scanning
				if (rd_entry.status == ST_RUNNING) begin
					wr_en            = 1'b1;
					wr_addr          = cur_q;
					wr_entry.wait_on = rd_entry.wait_on;
					wr_entry.status  = ST_READY;
				end
				scan_d   = CNT_W'(cur_q) + CNT_W'(1);
				looped_d = 1'b0;
				state_d  = S_SCAN_ADDR;
			end
			S_SCAN_ADDR: begin
				if (32'(scan_q) >= SLOT_COUNT) begin
					if (!looped_q) begin
						scan_d   = CNT_W'(1);
						looped_d = 1'b1;
					end else begin
						cur_d   = '0;
						state_d = S_DONE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_idx;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK, S_TGT_CHK: begin
				if ((state_q == S_SCAN_CHK && (rd_entry.status == ST_READY ||
				     (rd_entry.status == ST_WAITING &&
				      32'(rd_entry.wait_on) >= SLOT_COUNT))) ||
				    (state_q == S_TGT_CHK && rd_entry.status == ST_DEAD)) begin
					wr_en           = 1'b1;
					wr_addr         = scan_idx;
					wr_entry.status = ST_RUNNING;
					cur_d           = scan_idx;
					state_d         = S_DONE;
				end else if (state_q == S_SCAN_CHK && rd_entry.status == ST_WAITING) begin
					// look up the slot this one waits on
					rd_en   = 1'b1;
					rd_addr = IDX_W'(rd_entry.wait_on);
					state_d = S_TGT_CHK;
				end else begin
					scan_d = next_cnt;
					if (next_in) begin
						rd_en   = 1'b1;
						rd_addr = next_cnt[IDX_W-1:0];
						state_d = S_SCAN_CHK;
					end else begin
						state_d = S_SCAN_ADDR;
					end
				end
			end
			S_SPAWN_CHK: begin
				if (rd_entry.status == ST_DEAD) begin
					wr_en           = 1'b1;
					wr_addr         = scan_idx;
					wr_entry.status = ST_READY;
					spawned_d       = scan_idx;
					any_d           = 1'b1;
					state_d         = S_DONE;
				end else if (next_in) begin
					scan_d  = next_cnt;
					rd_en   = 1'b1;
					rd_addr = next_cnt[IDX_W-1:0];
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			spawned_q <= '0;
			scan_q    <= '0;
			looped_q  <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			spawned_q <= spawned_d;
			scan_q    <= scan_d;
			looped_q  <= looped_d;
			any_q     <= any_d;
		end
	end

	assign idle             = state_q == S_IDLE;
	assign done             = state_q == S_DONE;
	assign res.running_slot = 4'(cur_q);
	assign res.spawned_slot = 4'(spawned_q);

endmodule

FILE: rtl/core/round_robin_process_scheduler.sv
// Round-robin process scheduler, top level. Uses rrs_pkg, rrs_mem and rrs_seq.
// Kill finishes without a table read; spawn scans upward from slot 1 for a dead slot;
// tick and wait scan round-robin from the slot after the running one, two passes at most.
// One request in work at a time; the next is taken in the cycle after the result loads.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low): all slots dead, running slot 0, no spawn seen; takes effect at once.
module round_robin_process_scheduler import rrs_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic             start;
	logic             seq_idle;
	logic             seq_done;
	res_t             seq_res;
	logic             out_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_entry;
	logic             res_valid_q;
	res_t             res_q;

	// Take a request only while the sequencer is idle; the request itself
	// is consumed in the cycle it is accepted.
	assign req_stall = !seq_idle;
	assign start     = req_valid && !req_stall;

	// Output register is free when empty or being drained this cycle.
	assign out_free = !res_valid_q || !res_stall;

	// Task table: status and wait target per slot.
	rrs_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	// Command sequencer: decodes the request, scans the table round-robin.
	rrs_seq #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (seq_res),
		.out_free (out_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	// Load a finished result when the register can take it; drop valid once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_done && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled.
	always_ff @(posedge clk) begin
		if (seq_done && out_free) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/core/rrs_chk.sv
// Port-level checker for the round-robin process scheduler, bound to the top level.
// Tracks commands in flight to check result fields. Depends on rrs_pkg.
module rrs_chk import rrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	logic       push;
	logic       pop;
	logic [1:0] cnt_q;
	logic [1:0] fill;
	logic [1:0] cmd_q [2];
	logic [3:0] prev_run_q;
	logic       have_prev_q;

	assign push = req_valid && !req_stall;
	assign pop  = res_valid && !res_stall;
	assign fill = pop ? cnt_q - 2'd1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 2'd0;
			have_prev_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
			if (pop) begin
				have_prev_q <= 1'b1;
			end
		end
	end

	// Shift out the oldest command on pop, append the new one behind what remains.
	always_ff @(posedge clk) begin
		if (pop) begin
			prev_run_q <= res.running_slot;
		end
		if (push && fill == 2'd0) begin
			cmd_q[0] <= req.command;
		end else if (pop) begin
			cmd_q[0] <= cmd_q[1];
		end
		if (push && fill == 2'd1) begin
			cmd_q[1] <= req.command;
		end
	end

	// Result register holds while stalled.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// No result without an outstanding request.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != 2'd0)
		else $error("result without request");

	// At most one request in work plus one result waiting.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2 || pop)
		else $error("request taken while block full");

	// Only spawn reports a claimed slot.
	a_spawn_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cnt_q != 2'd0 && cmd_q[0] != CMD_SPAWN |-> res.spawned_slot == 4'd0)
		else $error("spawned slot on non-spawn command");

	// Kill and spawn never reschedule.
	a_no_resched: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cnt_q != 2'd0 && have_prev_q &&
		(cmd_q[0] == CMD_KILL || cmd_q[0] == CMD_SPAWN) |-> res.running_slot == prev_run_q)
		else $error("running slot changed on kill or spawn");

endmodule

bind round_robin_process_scheduler rrs_chk u_chk (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_process_scheduler: directed table, then random
// command episodes, each result checked against an in-bench scheduler model.
// Depends on rrs_pkg and the scheduler RTL.
module tb_top;
	import rrs_pkg::*;

	localparam int SLOTS        = SLOT_COUNT_DEF;
	// The limit allows for the worst-case scan per request plus long sender gaps and
	// receiver stalls across ~1100 requests.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 216;

	// One row of the directed script: a request repeated reps times; when pinned, the
	// typed-in result replaces the model's prediction for every repeat.
	typedef struct packed {
		req_t       rq;
		logic [7:0] reps;
		logic       pinned;
		res_t       want;
	} step_row_t;

	localparam int SCRIPT_ROWS = 11;
	localparam step_row_t SCRIPT [SCRIPT_ROWS] = '{
		// tick before any spawn: nothing is rescheduled, kernel keeps running
		'{'{CMD_TICK,  4'd0},  8'd1,  1'b1, '{4'd0, 4'd0}},
		// wait before any spawn: kernel slot is parked yet still reported as running
		'{'{CMD_WAIT,  4'd15}, 8'd1,  1'b1, '{4'd0, 4'd0}},
		// fill slots 1 to 14
		'{'{CMD_SPAWN, 4'd0},  8'd14, 1'b0, '{4'd0, 4'd0}},
		// the last free slot is the top of the table
		'{'{CMD_SPAWN, 4'd0},  8'd1,  1'b1, '{4'd0, 4'd15}},
		// table full: spawn is refused
		'{'{CMD_SPAWN, 4'd0},  8'd1,  1'b1, '{4'd0, 4'd0}},
		'{'{CMD_TICK,  4'd0},  8'd1,  1'b0, '{4'd0, 4'd0}},
		// running slot waits on the top slot, which is still alive
		'{'{CMD_WAIT,  4'd15}, 8'd1,  1'b0, '{4'd0, 4'd0}},
		// kill the waited-on slot so the waiter can wake later
		'{'{CMD_KILL,  4'd15}, 8'd1,  1'b0, '{4'd0, 4'd0}},
		// kill the running slot: running_slot must not move
		'{'{CMD_KILL,  4'd2},  8'd1,  1'b0, '{4'd0, 4'd0}},
		'{'{CMD_TICK,  4'd0},  8'd1,  1'b0, '{4'd0, 4'd0}},
		// wait on the kernel slot, which is parked rather than dead
		'{'{CMD_WAIT,  4'd0},  8'd1,  1'b0, '{4'd0, 4'd0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// Side data that travels with the request for the monitor
	logic req_pinned = 1'b0;
	res_t req_want = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int requests_taken = 0;
	int results_checked = 0;
	int kernel_falls = 0;
	int spawn_refusals = 0;

	// Scheduler model state
	logic [1:0] task_state [SLOTS];
	logic [3:0] task_waits [SLOTS];
	logic [3:0] run_slot;
	bit         started;

	res_t expected_results [$];

	round_robin_process_scheduler #(.SLOT_COUNT(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A target beyond the table counts as dead, so its waiter wakes.
	function automatic bit target_gone(logic [3:0] t);
		if (int'(t) >= SLOTS)
			return 1'b1;
		return task_state[t] == ST_DEAD;
	endfunction

	// Demote the running slot, then scan round-robin from the next slot; wrap to slot 1
	// once, and fall back to the kernel slot on the second end of table.
	function automatic void schedule_next();
		int idx;
		bit wrapped;
		if (!started)
			return;
		if (task_state[run_slot] == ST_RUNNING)
			task_state[run_slot] = ST_READY;
		idx = int'(run_slot) + 1;
		wrapped = 1'b0;
		for (int n = 0; n < 2 * SLOTS + 2; n++) begin
			if (idx >= SLOTS) begin
				if (wrapped)
					break;
				idx = 1;
				wrapped = 1'b1;
			end else if (task_state[idx] == ST_READY ||
					(task_state[idx] == ST_WAITING && target_gone(task_waits[idx]))) begin
				task_state[idx] = ST_RUNNING;
				run_slot = 4'(idx);
				return;
			end else begin
				idx++;
			end
		end
		// kernel slot status is left alone on fallback
		run_slot = '0;
		kernel_falls++;
	endfunction

	// Advance the model by one request and return the result it must produce.
	function automatic res_t apply_command(req_t r);
		res_t outcome;
		outcome.spawned_slot = '0;
		case (r.command)
		CMD_TICK: begin
			schedule_next();
		end
		CMD_WAIT: begin
			task_waits[run_slot] = r.target_slot;
			task_state[run_slot] = ST_WAITING;
			schedule_next();
		end
		CMD_KILL: begin
			if (int'(r.target_slot) < SLOTS)
				task_state[r.target_slot] = ST_DEAD;
		end
		default: begin
			for (int i = 1; i < SLOTS; i++)
				if (task_state[i] == ST_DEAD && outcome.spawned_slot == '0)
					outcome.spawned_slot = 4'(i);
			if (outcome.spawned_slot != '0) begin
				task_state[outcome.spawned_slot] = ST_READY;
				started = 1'b1;
			end else begin
				spawn_refusals++;
			end
		end
		endcase
		outcome.running_slot = run_slot;
		return outcome;
	endfunction

	task automatic flag_mismatch(input string what, input logic [3:0] got,
			input logic [3:0] want);
		$display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	// Monitor: sample both handshakes at the rising edge. Predict on each accepted
	// request, compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (req_valid && !req_stall) begin
			want = apply_command(req);
			if (req_pinned)
				want = req_want;
			expected_results.push_back(want);
			requests_taken++;
		end
		if (res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("result with no request pending", res.running_slot, '0);
			end else begin
				want = expected_results.pop_front();
				if (res.running_slot != want.running_slot)
					flag_mismatch("running_slot", res.running_slot, want.running_slot);
				if (res.spawned_slot != want.spawned_slot)
					flag_mismatch("spawned_slot", res.spawned_slot, want.spawned_slot);
				results_checked++;
			end
		end
	end

	// Receiver: stall at the current rate, one decision per falling edge.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drive one request from a falling edge and hold it until accepted; return at the
	// next falling edge with valid left as is, so the next call assigns it exactly once.
	task automatic send_request(input req_t r, input logic pinned, input res_t want);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		req_pinned <= pinned;
		req_want <= want;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Hold the sender off until every prediction has been matched. Always wait for
	// a falling edge first so valid is never assigned twice in one step.
	task automatic wait_for_results();
		do @(negedge clk); while (expected_results.size() != 0);
	endtask

	// Episode mixes: fill the table, churn it, or drain it toward the kernel fallback.
	// Target the running slot a third of the time so kills and self-waits hit it.
	function automatic req_t pick_request(int mode);
		req_t r;
		int roll;
		int lim_spawn;
		int lim_tick;
		int lim_wait;
		case (mode)
		0: begin
			lim_spawn = 45; lim_tick = 75; lim_wait = 88;
		end
		1: begin
			lim_spawn = 20; lim_tick = 55; lim_wait = 80;
		end
		default: begin
			lim_spawn = 10; lim_tick = 35; lim_wait = 50;
		end
		endcase
		roll = $urandom_range(99);
		if (roll < lim_spawn)
			r.command = CMD_SPAWN;
		else if (roll < lim_tick)
			r.command = CMD_TICK;
		else if (roll < lim_wait)
			r.command = CMD_WAIT;
		else
			r.command = CMD_KILL;
		r.target_slot = ($urandom_range(2) == 0) ? run_slot : 4'($urandom_range(SLOTS - 1));
		return r;
	endfunction

	task automatic run_phase(input int idle, input int stall, input int count,
			input bit hold_mid);
		int mode;
		idle_pct = idle;
		stall_pct = stall;
		mode = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0)
				mode = $urandom_range(2);
			// pause the sender mid-phase until the block has fully caught up
			if (hold_mid && k == count / 2) begin
				req_valid <= 1'b0;
				wait_for_results();
			end
			send_request(pick_request(mode), 1'b0, '0);
		end
		req_valid <= 1'b0;
		wait_for_results();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			task_state[i] = ST_DEAD;
			task_waits[i] = '0;
		end
		run_slot = '0;
		started = 1'b0;

		// Hold reset, then release it at a falling edge.
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed script, no idling on either side.
		for (int row = 0; row < SCRIPT_ROWS; row++)
			for (int n = 0; n < int'(SCRIPT[row].reps); n++)
				send_request(SCRIPT[row].rq, SCRIPT[row].pinned, SCRIPT[row].want);
		req_valid <= 1'b0;
		wait_for_results();

		// Random episodes under each idling pattern.
		run_phase(0, 0, PHASE_ITEMS, 1'b0);
		run_phase(73, 0, PHASE_ITEMS, 1'b0);
		run_phase(0, 73, PHASE_ITEMS, 1'b0);
		run_phase(25, 25, PHASE_ITEMS, 1'b1);
		run_phase(0, 0, PHASE_ITEMS, 1'b1);

		// Let any stray result show up before the verdict.
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d requests, %0d results checked across five idling phases.",
			requests_taken, results_checked);
		$display("Saw %0d kernel fallbacks and %0d refused spawns; %0d mismatches.",
			kernel_falls, spawn_refusals, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
